/* hw/rtl/srg_pkg.sv */
// ----------------------------------------------------------------------------
// srg_pkg: shared types and constants of the stepper speed ramp
// Command codes, sequencer states and fixed datapath widths.
// ----------------------------------------------------------------------------
package srg_pkg;

  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_INIT_ACCEL = 2'd0,
    REG_INIT_VEL   = 2'd1,
    REG_GAIN       = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_SQRT = 7'b0000100,
    ST_MUL1 = 7'b0001000,
    ST_MUL2 = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  // Radicand covers v^2 (48 bits) plus the largest acceleration term.
  localparam int unsigned SQ_W   = 50;
  localparam int unsigned ROOT_W = SQ_W / 2;
  localparam int unsigned SQ_ITER_W = 5;
  localparam int unsigned P1_W   = ROOT_W + 16;
  localparam int unsigned P2_W   = P1_W + 18;
  localparam int unsigned QUOT_W = P2_W - 48;
  localparam int unsigned DIV_CNT_W = 4;
  localparam logic [15:0] PERIOD_SCALE = 16'd40000;
  localparam logic [23:0] MAX24 = 24'hFFFFFF;

  function automatic logic [31:0] sat_dist(input logic signed [32:0] v);
    logic [31:0] r;
    if (v > 33'sd2147483647) begin
      r = 32'h7FFFFFFF;
    end else if (v < -33'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/srg_isqrt.sv */
// ----------------------------------------------------------------------------
// srg_isqrt: iterative integer square root
// Bit-pair restoring root, one result bit per cycle.
// ----------------------------------------------------------------------------
module srg_isqrt
  import srg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   radicand_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [SQ_W-1:0]      x_q, x_d;
  logic [SQ_W-1:0]      res_q, res_d;
  logic [SQ_W-1:0]      bit_q, bit_d;
  logic [SQ_ITER_W-1:0] cnt_q, cnt_d;
  logic [SQ_W-1:0]      trial;

  assign trial = res_q + bit_q;

  always_comb begin
    x_d   = x_q;
    res_d = res_q;
    bit_d = bit_q;
    cnt_d = cnt_q;
    if (start_i) begin
      x_d   = radicand_i;
      res_d = '0;
      bit_d = {2'b01, {(SQ_W - 2){1'b0}}};
      cnt_d = SQ_ITER_W'(ROOT_W);
    end else if (cnt_q != '0) begin
      if (x_q >= trial) begin
        x_d   = x_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign busy_o = (cnt_q != '0);
  assign root_o = res_q[ROOT_W-1:0];

endmodule

/* hw/rtl/stepper_ramp_with_decel_trigger.sv */
// ----------------------------------------------------------------------------
// stepper_ramp_with_decel_trigger: two-wheel trapezoidal speed ramp
// Tracks wheel distances and velocities and turns each step into a period.
// ----------------------------------------------------------------------------
// The input channel carries one command per beat: reset motion, load a move
// segment, or step one wheel. Every command returns exactly one result beat.
// Reset, load and the unused code finish at once: their result is registered
// at the accepting edge, and the next command may follow as soon as the
// output register is free. A step passes through a setup state, the
// iterative root unit, the multiply states MUL1 and MUL2, a restoring divider
// and a final state that loads the result register; a zero acceleration
// skips the divider. The input is stalled from the accepted step until the
// sequencer returns to idle.
// The configuration port writes initial acceleration, initial velocity and
// the period gain; writes take effect at the edge.
// After reset all motion state is zero and the gain is one (65536).
// The result sits in an output register. While the receiver stalls, a reset
// or load command may still enter only if the register holds no result;
// a finished step waits in its last state until the register is free.
// ----------------------------------------------------------------------------
module stepper_ramp_with_decel_trigger
  import srg_pkg::*;
#(
  parameter int unsigned STEP_DISTANCE_Q17   = 1024,
  parameter int unsigned TWICE_STEP_DISTANCE = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic        wheel_i,
  input  logic signed [31:0] move_distance_i,
  input  logic [30:0] decel_distance_i,
  input  logic [23:0] target_velocity_i,
  input  logic [23:0] decel_velocity_i,
  input  logic [15:0] acceleration_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] step_period_o,
  output logic [23:0] next_velocity_o,
  output logic signed [31:0] distance_remaining_o,
  output logic        decel_fired_o,
  output logic        period_saturated_o
);

  // configuration
  logic [15:0] init_accel_q;
  logic [23:0] init_vel_q;
  logic [17:0] gain_q;

  // motion state
  logic signed [31:0] ltot_q, rtot_q, seg_q;
  logic [23:0] lvel_q, rvel_q, tspeed_q, slow_q;
  logic [15:0] taccel_q;
  logic [30:0] trig_q;
  logic        armed_q;

  // step working registers
  state_e state_q;
  logic        wheel_q, rising_q;
  logic [23:0] v_q;
  logic [ROOT_W-1:0] dv_q;
  logic [P1_W-1:0]   p1_q;
  logic [QUOT_W-1:0] dividend_q, quot_q;
  logic [16:0]       rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [31:0] step_err_q;
  logic        step_fired_q;

  // output register
  logic        out_valid_q;
  logic [23:0] period_q, nvel_q;
  logic [31:0] dist_q;
  logic        fired_q, sat_q;

  logic accept, out_free, res_load;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign res_load   = (accept && (cmd_e'(command_i) != CMD_STEP)) ||
                      ((state_q == ST_DONE) && out_free);

  // step distance bookkeeping
  logic signed [31:0] tot_sel, tot_new, left_now;
  logic signed [32:0] tot_sum, err, lerr, labs, load_err;
  logic fire;
  logic [23:0] tspeed_eff, vel_sel;

  always_comb begin
    tot_sel  = wheel_i ? rtot_q : ltot_q;
    tot_sum  = 33'(tot_sel) + 33'(STEP_DISTANCE_Q17);
    tot_new  = (tot_sum > 33'sd2147483647) ? 32'sh7FFFFFFF : tot_sum[31:0];
    err      = 33'(seg_q) - 33'(tot_new);
    left_now = wheel_i ? ltot_q : tot_new;
    lerr     = 33'(seg_q) - 33'(left_now);
    labs     = lerr[32] ? -lerr : lerr;
    fire     = armed_q && ($signed({2'b00, trig_q}) >= labs);
    tspeed_eff = fire ? slow_q : tspeed_q;
    vel_sel  = wheel_i ? rvel_q : lvel_q;
    load_err = 33'(move_distance_i) - 33'(ltot_q);
  end

  // square root operand
  logic [SQ_W-1:0] vsq, amp, radicand;
  always_comb begin
    vsq = SQ_W'(48'(v_q) * 48'(v_q));
    amp = SQ_W'(SQ_W'(TWICE_STEP_DISTANCE) * SQ_W'(taccel_q)) << 16;
    if (rising_q) begin
      radicand = vsq + amp;
    end else begin
      radicand = (vsq > amp) ? (vsq - amp) : '0;
    end
  end

  logic sq_start, sq_busy;
  logic [ROOT_W-1:0] root;
  assign sq_start = (state_q == ST_PREP);

  srg_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (radicand),
    .busy_o     (sq_busy),
    .root_o     (root)
  );

  // velocity update from the root
  logic [ROOT_W-1:0] v_ext, dv_new, tsp_ext;
  logic [23:0]       nvel_new;
  always_comb begin
    v_ext   = ROOT_W'(v_q);
    tsp_ext = ROOT_W'(tspeed_q);
    if (rising_q) begin
      dv_new   = root - v_ext;
      nvel_new = (tsp_ext <= root) ? tspeed_q : root[23:0];
    end else begin
      dv_new   = v_ext - root;
      nvel_new = (tsp_ext >= root) ? tspeed_q : root[23:0];
    end
  end

  logic [P2_W-1:0] p2;
  assign p2 = P2_W'(p1_q) * P2_W'(gain_q);

  logic [16:0] div_trial;
  logic        div_ge;
  assign div_trial = {rem_q[15:0], dividend_q[QUOT_W-1]};
  assign div_ge    = (div_trial >= {1'b0, taccel_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_accel_q <= '0;
      init_vel_q   <= '0;
      gain_q       <= 18'd65536;
      ltot_q   <= '0;
      rtot_q   <= '0;
      seg_q    <= '0;
      lvel_q   <= '0;
      rvel_q   <= '0;
      tspeed_q <= '0;
      slow_q   <= '0;
      taccel_q <= '0;
      trig_q   <= '0;
      armed_q  <= 1'b0;
      state_q  <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_INIT_ACCEL: init_accel_q <= cfg_data_i[15:0];
          REG_INIT_VEL:   init_vel_q   <= cfg_data_i;
          REG_GAIN:       gain_q       <= 18'(cfg_data_i);
          default: ;
        endcase
      end

      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd_e'(command_i))
              CMD_RESET: begin
                ltot_q   <= '0;
                rtot_q   <= '0;
                seg_q    <= '0;
                lvel_q   <= '0;
                rvel_q   <= '0;
                slow_q   <= '0;
                trig_q   <= '0;
                armed_q  <= 1'b0;
                taccel_q <= init_accel_q;
                tspeed_q <= init_vel_q;
              end
              CMD_LOAD: begin
                seg_q    <= move_distance_i;
                trig_q   <= decel_distance_i;
                tspeed_q <= target_velocity_i;
                slow_q   <= decel_velocity_i;
                taccel_q <= acceleration_i;
                armed_q  <= 1'b1;
              end
              CMD_STEP: begin
                if (wheel_i) begin
                  rtot_q <= tot_new;
                end else begin
                  ltot_q <= tot_new;
                end
                if (fire) begin
                  tspeed_q <= slow_q;
                  armed_q  <= 1'b0;
                end
                state_q <= ST_PREP;
              end
              default: ;
            endcase
          end
        end
        ST_PREP: state_q <= ST_SQRT;
        ST_SQRT: begin
          if (!sq_busy) begin
            if (wheel_q) begin
              rvel_q <= nvel_new;
            end else begin
              lvel_q <= nvel_new;
            end
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: state_q <= ST_MUL2;
        ST_MUL2: state_q <= (taccel_q == '0) ? ST_DONE : ST_DIV;
        ST_DIV: begin
          if (div_cnt_q == DIV_CNT_W'(1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        wheel_q      <= wheel_i;
        v_q          <= vel_sel;
        rising_q     <= (vel_sel < tspeed_eff);
        step_err_q   <= sat_dist(err);
        step_fired_q <= fire;
        if (accept) begin
          period_q <= '0;
          nvel_q   <= '0;
          fired_q  <= 1'b0;
          sat_q    <= 1'b0;
          dist_q   <= (cmd_e'(command_i) == CMD_LOAD) ? sat_dist(load_err) : '0;
        end
      end
      ST_SQRT: begin
        dv_q   <= dv_new;
        nvel_q <= nvel_new;
      end
      ST_MUL1: p1_q <= P1_W'(dv_q) * P1_W'(PERIOD_SCALE);
      ST_MUL2: begin
        dividend_q <= p2[P2_W-1:48];
        rem_q      <= '0;
        quot_q     <= '0;
        div_cnt_q  <= DIV_CNT_W'(QUOT_W);
      end
      ST_DIV: begin
        rem_q      <= div_ge ? (div_trial - {1'b0, taccel_q}) : div_trial;
        quot_q     <= {quot_q[QUOT_W-2:0], div_ge};
        dividend_q <= dividend_q << 1;
        div_cnt_q  <= div_cnt_q - 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          // The quotient is far narrower than 24 bits, so only a zero
          // acceleration can saturate the period.
          period_q <= (taccel_q == '0) ? MAX24 : 24'(quot_q);
          sat_q    <= (taccel_q == '0);
          dist_q   <= step_err_q;
          fired_q  <= step_fired_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o          = out_valid_q;
  assign step_period_o        = period_q;
  assign next_velocity_o      = nvel_q;
  assign distance_remaining_o = dist_q;
  assign decel_fired_o        = fired_q;
  assign period_saturated_o   = sat_q;

  // A step beat holds the input stalled on the following cycle.
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (command_i == CMD_STEP) |=> in_stall_o)
    else $error("step accepted but input not stalled");

  // A saturated period always reads as the maximum.
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && period_saturated_o |-> step_period_o == MAX24)
    else $error("saturated period not at maximum");

  // A fired deceleration leaves the segment disarmed.
  a_fire_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decel_fired_o |-> !armed_q)
    else $error("deceleration fired but still armed");

  // The root unit only runs while the sequencer waits for it.
  a_sqrt_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_busy |-> state_q == ST_SQRT)
    else $error("root unit busy outside its state");

endmodule
